>>> src/lzbp_pkg.sv
// Shared constants and controller/datapath command and status types for the LZ byte-pair decoder.
`default_nettype none

package lzbp_pkg;

	localparam int BYTE_W  = 8;
	localparam int LANES   = 4;
	localparam int LANE_W  = 2;
	localparam int COUNT_W = 3;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic restart;    // clear write pointer and produced count
		logic load_len;   // capture length byte
		logic load_lit;   // capture literal run length
		logic lit_dec;    // count down literal run
		logic emit_lit;   // write one literal to history and result
		logic emit_bad;   // post a bad-reference result
		logic start_copy; // set up copy pointers and counters
		logic copy_en;    // copy sequence owns the datapath
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic out_free;   // result register can take a new result
		logic len_zero;   // stored length byte is zero
		logic data_zero;  // incoming byte is zero
		logic bad_ref;    // distance reaches before block start
		logic lit_last;   // this literal ends the run
		logic copy_done;  // final copied byte leaves this cycle
	} stat_t;

endpackage

`default_nettype wire

>>> src/lzbp_in_if.sv
// Compressed byte request channel.
`default_nettype none

interface lzbp_in_if;
	import lzbp_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              block_start;

	modport source (output valid, output data_byte, output block_start, input ready);
	modport sink   (input valid, input data_byte, input block_start, output ready);
endinterface

`default_nettype wire

>>> src/lzbp_out_if.sv
// Decoded result request channel.
`default_nettype none

interface lzbp_out_if;
	import lzbp_pkg::*;

	logic               valid;
	logic               ready;
	logic [BYTE_W-1:0]  out_byte0;
	logic [BYTE_W-1:0]  out_byte1;
	logic [BYTE_W-1:0]  out_byte2;
	logic [BYTE_W-1:0]  out_byte3;
	logic [COUNT_W-1:0] byte_count;
	logic               last;
	logic               bad_reference;

	modport source (output valid, output out_byte0, output out_byte1, output out_byte2,
		output out_byte3, output byte_count, output last, output bad_reference,
		input ready);
	modport sink   (input valid, input out_byte0, input out_byte1, input out_byte2,
		input out_byte3, input byte_count, input last, input bad_reference,
		output ready);
endinterface

`default_nettype wire

>>> src/lzbp_ctrl.sv
// Token-phase controller: decodes stream position and sequences copies.
`default_nettype none

module lzbp_ctrl
	import lzbp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	input  wire logic  block_start,
	output logic       in_ready,
	output cmd_t       cmd,
	input  wire stat_t stat
);

	typedef enum logic {
		ST_TOKEN,
		ST_COPY
	} state_t;

	typedef enum logic [1:0] {
		PH_LENGTH,
		PH_DISTANCE,
		PH_LITERAL,
		PH_TRAIL
	} phase_t;

	state_t state_q, state_nxt;
	phase_t phase_q, phase_nxt, phase_cur;
	logic   acc;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		phase_nxt = phase_q;
		in_ready  = (state_q == ST_TOKEN) && stat.out_free;
		acc       = in_valid && in_ready;
		// a block start drops any unfinished token
		phase_cur = block_start ? PH_LENGTH : phase_q;

		cmd.copy_en = (state_q == ST_COPY);
		if ((state_q == ST_COPY) && stat.copy_done) begin
			state_nxt = ST_TOKEN;
		end

		if (acc) begin
			cmd.restart = block_start;
			unique case (phase_cur)
				PH_LENGTH: begin
					cmd.load_len = 1'b1;
					phase_nxt    = PH_DISTANCE;
				end
				PH_DISTANCE: begin
					if (stat.len_zero) begin
						cmd.load_lit = 1'b1;
						phase_nxt    = stat.data_zero ? PH_LENGTH : PH_LITERAL;
					end else if (stat.bad_ref) begin
						cmd.emit_bad = 1'b1;
						phase_nxt    = PH_TRAIL;
					end else begin
						cmd.start_copy = 1'b1;
						phase_nxt      = PH_TRAIL;
						state_nxt      = ST_COPY;
					end
				end
				PH_LITERAL: begin
					cmd.emit_lit = 1'b1;
					cmd.lit_dec  = 1'b1;
					phase_nxt    = stat.lit_last ? PH_LENGTH : PH_LITERAL;
				end
				PH_TRAIL: begin
					cmd.emit_lit = 1'b1;
					phase_nxt    = PH_LENGTH;
				end
				default: begin
					phase_nxt = PH_LENGTH;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_TOKEN;
			phase_q <= PH_LENGTH;
		end else begin
			state_q <= state_nxt;
			phase_q <= phase_nxt;
		end
	end

endmodule

`default_nettype wire

>>> src/lzbp_datapath.sv
// History memory, copy pointers, result packing and result register.
`default_nettype none

module lzbp_datapath
	import lzbp_pkg::*;
#(
	parameter int HISTORY_DEPTH = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [BYTE_W-1:0] data_byte,
	input  wire cmd_t              cmd,
	output stat_t                  stat,
	lzbp_out_if.source             decoded
);

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam int CW = AW + 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C   = CW'(HISTORY_DEPTH);

	logic [BYTE_W-1:0] hist_q [HISTORY_DEPTH];
	logic [BYTE_W-1:0] rdata_q;
	logic [BYTE_W-1:0] bypd_q;
	logic              byp_q;

	logic [BYTE_W-1:0] len_q;
	logic [BYTE_W-1:0] lit_left_q;
	logic [AW-1:0]     wp_q;
	logic [CW-1:0]     produced_q;
	logic [AW-1:0]     rd_q;
	logic [BYTE_W-1:0] reads_left_q;
	logic [BYTE_W-1:0] cons_left_q;
	logic              dv_q;

	logic [LANES-1:0][BYTE_W-1:0] pack_q;
	logic [LANE_W-1:0]            fill_q;

	logic                         out_valid_q;
	logic [LANES-1:0][BYTE_W-1:0] out_lanes_q;
	logic [COUNT_W-1:0]           out_count_q;
	logic                         out_last_q;
	logic                         out_bad_q;

	logic [CW-1:0]                dist1;
	logic [AW-1:0]                start_rd;
	logic                         advance;
	logic                         issue;
	logic                         consume;
	logic                         we;
	logic [BYTE_W-1:0]            wdata;
	logic [BYTE_W-1:0]            copy_byte;
	logic                         flush;
	logic [LANES-1:0][BYTE_W-1:0] flush_lanes;

	always_comb begin
		dist1 = CW'(data_byte) + CW'(1);
		if (CW'(wp_q) >= dist1) begin
			start_rd = AW'(CW'(wp_q) - dist1);
		end else begin
			start_rd = AW'(CW'(wp_q) + DEPTH_C - dist1);
		end

		stat.out_free  = !out_valid_q || decoded.ready;
		stat.len_zero  = (len_q == '0);
		stat.data_zero = (data_byte == '0);
		stat.bad_ref   = dist1 > produced_q;
		stat.lit_last  = (lit_left_q < BYTE_W'(2));

		// copy pipeline: each step issues at most one read and consumes at most one byte
		advance   = cmd.copy_en && (!dv_q || stat.out_free);
		issue     = advance && (reads_left_q != '0);
		consume   = advance && dv_q;
		copy_byte = byp_q ? bypd_q : rdata_q;
		stat.copy_done = consume && (cons_left_q == BYTE_W'(1));

		we    = cmd.emit_lit || consume;
		wdata = cmd.emit_lit ? data_byte : copy_byte;

		flush = consume && ((fill_q == LANE_W'(LANES - 1)) || (cons_left_q == BYTE_W'(1)));
		for (int i = 0; i < LANES; i++) begin
			if (LANE_W'(i) < fill_q) begin
				flush_lanes[i] = pack_q[i];
			end else if (LANE_W'(i) == fill_q) begin
				flush_lanes[i] = copy_byte;
			end else begin
				flush_lanes[i] = '0;
			end
		end
	end

	// history memory with a bypass for a read of the address written the same cycle
	always_ff @(posedge clk) begin
		if (we) begin
			hist_q[wp_q] <= wdata;
		end
		if (issue) begin
			rdata_q <= hist_q[rd_q];
			byp_q   <= we && (wp_q == rd_q);
			bypd_q  <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_len) begin
			len_q <= data_byte;
		end
		if (cmd.start_copy) begin
			rd_q <= start_rd;
		end else if (issue) begin
			rd_q <= (rd_q == LAST_ADDR) ? '0 : rd_q + AW'(1);
		end
		if (consume && !flush) begin
			pack_q[fill_q] <= copy_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lit_left_q   <= '0;
			wp_q         <= '0;
			produced_q   <= '0;
			reads_left_q <= '0;
			cons_left_q  <= '0;
			dv_q         <= 1'b0;
			fill_q       <= '0;
		end else begin
			if (cmd.load_lit) begin
				lit_left_q <= data_byte;
			end else if (cmd.lit_dec && (lit_left_q != '0)) begin
				lit_left_q <= lit_left_q - BYTE_W'(1);
			end

			if (cmd.restart) begin
				wp_q       <= '0;
				produced_q <= '0;
			end else if (we) begin
				wp_q <= (wp_q == LAST_ADDR) ? '0 : wp_q + AW'(1);
				if (produced_q != DEPTH_C) begin
					produced_q <= produced_q + CW'(1);
				end
			end

			if (cmd.start_copy) begin
				reads_left_q <= len_q;
				cons_left_q  <= len_q;
				dv_q         <= 1'b0;
				fill_q       <= '0;
			end else begin
				if (issue) begin
					reads_left_q <= reads_left_q - BYTE_W'(1);
				end
				if (consume) begin
					cons_left_q <= cons_left_q - BYTE_W'(1);
					fill_q      <= flush ? '0 : fill_q + LANE_W'(1);
				end
				if (advance) begin
					dv_q <= issue;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_lit || cmd.emit_bad || flush) begin
			out_valid_q <= 1'b1;
		end else if (decoded.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		priority if (cmd.emit_lit) begin
			out_lanes_q <= {{((LANES - 1) * BYTE_W){1'b0}}, data_byte};
			out_count_q <= COUNT_W'(1);
			out_last_q  <= 1'b1;
			out_bad_q   <= 1'b0;
		end else if (cmd.emit_bad) begin
			out_lanes_q <= '0;
			out_count_q <= '0;
			out_last_q  <= 1'b1;
			out_bad_q   <= 1'b1;
		end else if (flush) begin
			out_lanes_q <= flush_lanes;
			out_count_q <= COUNT_W'(fill_q) + COUNT_W'(1);
			out_last_q  <= (cons_left_q == BYTE_W'(1));
			out_bad_q   <= 1'b0;
		end
	end

	assign decoded.valid         = out_valid_q;
	assign decoded.out_byte0     = out_lanes_q[0];
	assign decoded.out_byte1     = out_lanes_q[1];
	assign decoded.out_byte2     = out_lanes_q[2];
	assign decoded.out_byte3     = out_lanes_q[3];
	assign decoded.byte_count    = out_count_q;
	assign decoded.last          = out_last_q;
	assign decoded.bad_reference = out_bad_q;

	a_bad_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_bad_q) |-> (out_count_q == '0) && out_last_q)
		else $error("bad-reference result carries bytes or is not last");

	a_reads_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		reads_left_q <= cons_left_q)
		else $error("copy reads fell behind consumed bytes");

	a_data_pending: assert property (@(posedge clk) disable iff (!arst_n)
		dv_q |-> (cons_left_q != '0))
		else $error("read data pending with no byte left to copy");

	a_produced_cap: assert property (@(posedge clk) disable iff (!arst_n)
		produced_q <= DEPTH_C)
		else $error("produced count passed the history depth");

endmodule

`default_nettype wire

>>> src/lz_byte_pair_decompressor_unit.sv
// Top level of the LZ byte-pair decompressor: controller plus datapath.
//
// Takes one compressed byte per request on the compressed channel and returns decoded
// bytes packed up to four per request on the decoded channel, with last set on the final
// result of each input byte and bad_reference set on a copy that reaches before the block
// start (that result carries no bytes). Length bytes, distance bytes that open a literal
// run, literal bytes and trailing literals can follow back to back while the decoded side
// keeps up. A distance byte that starts a copy of L bytes holds the input until the copy
// has consumed its last byte, and the next byte can be taken after that: the history is a
// single memory that writes one byte and reads one byte per cycle, with a registered read,
// so the copy walks it one byte a cycle while the decoded side keeps up. A stalled decoded
// channel holds the copy in place. The history is HISTORY_DEPTH bytes and needs no clearing
// after reset, since only bytes written in the current block are ever read.
`default_nettype none

module lz_byte_pair_decompressor_unit
	import lzbp_pkg::*;
#(
	parameter int HISTORY_DEPTH = 256
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lzbp_in_if.sink    compressed,
	lzbp_out_if.source decoded
);

	cmd_t  cmd;
	stat_t stat;
	logic  in_ready;

	// controller owns the token phase and the copy sequence
	lzbp_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (compressed.valid),
		.block_start (compressed.block_start),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.stat        (stat)
	);

	// datapath holds history, pointers, packing and the result register
	lzbp_datapath #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (compressed.data_byte),
		.cmd       (cmd),
		.stat      (stat),
		.decoded   (decoded)
	);

	assign compressed.ready = in_ready;

endmodule

`default_nettype wire
